// File: hw/rtl/spvf_pkg.sv
// Shared types and constants for the sample playback voice.
// Used by spvf_mult and the top level of the voice; depends on nothing else.
package spvf_pkg;

  // Item command codes.
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_REQUEST = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;

  // Playback request codes.
  localparam logic [1:0] REQ_PLAY  = 2'd0;
  localparam logic [1:0] REQ_PAUSE = 2'd1;
  localparam logic [1:0] REQ_STOP  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SAMPLE_LENGTH = 2'd0;
  localparam logic [1:0] CFG_RATE_ADJUST   = 2'd1;
  localparam logic [1:0] CFG_LOOP_ENABLE   = 2'd2;

  // Voice play states, also reported as status.
  localparam logic [2:0] ST_STOPPED    = 3'd0;
  localparam logic [2:0] ST_PAUSED     = 3'd1;
  localparam logic [2:0] ST_FADE_IN    = 3'd2;
  localparam logic [2:0] ST_FULL       = 3'd3;
  localparam logic [2:0] ST_FADE_PAUSE = 3'd4;
  localparam logic [2:0] ST_FADE_STOP  = 3'd5;

  // Fade step of 0.005 in Q1.16 and full scale volume.
  localparam int FADE_STEP = 328;
  localparam int VOL_ONE   = 65536;

  // Shared multiplier operand widths and the scaled speed width.
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int SPD_W   = 26;

  localparam int CFG_DATA_W = 16;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [11:0]         load_address;
    logic signed [15:0]  load_value;
    logic [1:0]          request;
    logic signed [23:0]  speed;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0]  sample_out;
    logic [2:0]          status;
    logic [11:0]         position_index;
  } out_item_t;

endpackage

// File: hw/rtl/spvf_store.sv
// Sample store of the playback voice: one write port, one registered read port.
// Depends on no package; depth and address width come from parameters.
module spvf_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic signed [15:0] wr_data,
  input  logic [AW-1:0]      rd_addr,
  output logic signed [15:0] rd_data
);

  logic signed [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hw/rtl/spvf_mult.sv
// Shared signed multiplier of the playback voice with a registered product.
// Depends on spvf_pkg for the operand widths.
module spvf_mult (
  input  logic                              clk,
  input  logic signed [spvf_pkg::MUL_A_W-1:0] op_a,
  input  logic signed [spvf_pkg::MUL_B_W-1:0] op_b,
  output logic signed [spvf_pkg::PROD_W-1:0]  prod
);
  import spvf_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(op_a) * PROD_W'(op_b);
  end

endmodule

// File: hw/rtl/sample_playback_voice_with_fades.sv
// Top level of the mono sample playback voice with fade in and fade out.
// Depends on spvf_pkg, spvf_store and spvf_mult.
//
//   Channel   Signals                              Direction
//   item      item, item_valid, item_stall         into the voice
//   result    result, result_valid, result_stall   out of the voice
//   config    cfg_index, cfg_data, cfg_valid,      into the voice
//             cfg_ready
//
// A load or request transaction is handled in the idle state. A tick while
// stopped or paused goes from idle straight to emit. A tick while playing steps
// through the speed multiply, volume multiply, add, wrap, finish and emit states,
// staying in wrap for every add or subtract of the sample length that the
// position wrap needs; the wrap runs on the single shared adder, so a fast speed
// over a short sample needs more corrections. Reset is synchronous and active
// high and restores the register defaults; the sample store keeps its contents.
// A stalled result waits in the sequencer until the output register frees up.
module sample_playback_voice_with_fades #(
  parameter int SAMPLE_DEPTH = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  spvf_pkg::in_item_t                item,
  input  logic                              item_valid,
  output logic                              item_stall,
  output spvf_pkg::out_item_t               result,
  output logic                              result_valid,
  input  logic                              result_stall,
  input  logic [1:0]                        cfg_index,
  input  logic [spvf_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready
);
  import spvf_pkg::*;

  // The store index covers the depth; position is that index plus 16 fraction
  // bits. The working position is wide enough to hold any sum before wrapping.
  localparam int IDX_W = $clog2(SAMPLE_DEPTH);
  localparam int LEN_W = IDX_W + 1;
  localparam int POS_W = IDX_W + 16;
  localparam int NP_W  = ((POS_W > SPD_W) ? POS_W : SPD_W) + 2;

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MULS   = 3'd1;
  localparam logic [2:0] S_MULV   = 3'd2;
  localparam logic [2:0] S_ADD    = 3'd3;
  localparam logic [2:0] S_WRAP   = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  // Configuration registers.
  logic [12:0] sample_length;
  logic [15:0] rate_adjust;
  logic        loop_enable;

  // Voice state.
  logic [POS_W-1:0] position;
  logic [16:0]      fade_volume;
  logic [2:0]       play_state;

  // Sequencer and working registers of a tick.
  logic [2:0]              seq;
  logic signed [23:0]      speed_reg;
  logic signed [SPD_W-1:0] spd;
  logic signed [NP_W-1:0]  np;
  logic                    stop_end;
  logic signed [15:0]      outv;

  // Datapath signals.
  logic                        accept;
  logic [31:0]                 addr_wide;
  logic                        wr_en;
  logic signed [15:0]          rd_data;
  logic signed [MUL_A_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]    prod;
  logic signed [PROD_W-1:0]    prod_rnd;
  logic [31:0]                 len_wide;
  logic [LEN_W-1:0]            eff_len;
  logic signed [NP_W-1:0]      len16;
  logic signed [NP_W-1:0]      alu_a;
  logic signed [NP_W-1:0]      alu_b;
  logic signed [NP_W-1:0]      alu_sum;
  logic signed [18:0]          vol_step;
  logic [16:0]                 vol_clamped;
  logic [31:0]                 pos_idx_wide;
  logic                        out_free;

  assign cfg_ready  = 1'b1;
  assign item_stall = (seq != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  // Loads outside the store are dropped.
  assign addr_wide = 32'(item.load_address);
  assign wr_en     = accept && (item.cmd == CMD_LOAD) && (addr_wide < 32'(SAMPLE_DEPTH));

  spvf_store #(
    .DEPTH (SAMPLE_DEPTH),
    .AW    (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr_wide[IDX_W-1:0]),
    .wr_data (item.load_value),
    .rd_addr (position[POS_W-1:16]),
    .rd_data (rd_data)
  );

  // The multiplier first scales the speed by the rate adjustment, then
  // applies the fade volume to the stored sample.
  always_comb begin
    if (seq == S_MULS) begin
      mul_a = MUL_A_W'(speed_reg);
      mul_b = $signed(MUL_B_W'(rate_adjust));
    end else begin
      mul_a = MUL_A_W'(rd_data);
      mul_b = $signed(MUL_B_W'(fade_volume));
    end
  end

  spvf_mult u_mult (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  // Rounding to nearest with halves up; the shift is then a bit select.
  assign prod_rnd = prod + PROD_W'(32768);

  // Effective length: zero counts as one, and it never exceeds the store.
  always_comb begin
    len_wide = (sample_length == 13'd0) ? 32'd1 : 32'(sample_length);
    if (len_wide > 32'(SAMPLE_DEPTH)) begin
      len_wide = 32'(SAMPLE_DEPTH);
    end
  end
  assign eff_len = len_wide[LEN_W-1:0];
  assign len16   = NP_W'({eff_len, 16'h0000});

  // The shared adder: position plus speed, then repeated length corrections.
  always_comb begin
    if (seq == S_ADD) begin
      alu_a = NP_W'(position);
      alu_b = NP_W'(spd);
    end else begin
      alu_a = np;
      alu_b = np[NP_W-1] ? len16 : -len16;
    end
  end
  assign alu_sum = alu_a + alu_b;

  // Fade ramp with the clamp to [0, 1.0] applied on every tick while playing.
  always_comb begin
    vol_step = $signed({2'b00, fade_volume});
    case (play_state)
      ST_FADE_IN: begin
        vol_step = vol_step + 19'(FADE_STEP);
      end
      ST_FADE_PAUSE, ST_FADE_STOP: begin
        vol_step = vol_step - 19'(FADE_STEP);
      end
      default: begin
      end
    endcase
    if (vol_step < 19'sd0) begin
      vol_clamped = 17'd0;
    end else if (vol_step > 19'(VOL_ONE)) begin
      vol_clamped = 17'(VOL_ONE);
    end else begin
      vol_clamped = vol_step[16:0];
    end
  end

  assign pos_idx_wide = 32'(position[POS_W-1:16]);

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_length <= 13'd4096;
      rate_adjust   <= 16'd16384;
      loop_enable   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SAMPLE_LENGTH: sample_length <= cfg_data[12:0];
        CFG_RATE_ADJUST:   rate_adjust   <= cfg_data;
        CFG_LOOP_ENABLE:   loop_enable   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Output register; it drains whenever the downstream side is not stalling.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (seq == S_EMIT && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq == S_EMIT && out_free) begin
      result.sample_out     <= outv;
      result.status         <= play_state;
      result.position_index <= pos_idx_wide[11:0];
    end
  end

  // Sequencer with the voice state it updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      seq         <= S_IDLE;
      position    <= '0;
      fade_volume <= '0;
      play_state  <= ST_STOPPED;
    end else begin
      case (seq)
        S_IDLE: begin
          if (accept) begin
            case (item.cmd)
              CMD_REQUEST: begin
                case (item.request)
                  REQ_PLAY: begin
                    if (play_state inside {ST_STOPPED, ST_PAUSED, ST_FADE_PAUSE,
                                           ST_FADE_STOP}) begin
                      play_state  <= ST_FADE_IN;
                      fade_volume <= '0;
                    end
                  end
                  REQ_PAUSE: begin
                    if (play_state inside {ST_FADE_IN, ST_FULL}) begin
                      play_state <= ST_FADE_PAUSE;
                    end
                  end
                  REQ_STOP: begin
                    if (play_state inside {ST_FADE_IN, ST_FULL, ST_FADE_PAUSE}) begin
                      play_state <= ST_FADE_STOP;
                    end else if (play_state == ST_PAUSED) begin
                      play_state  <= ST_STOPPED;
                      position    <= '0;
                      fade_volume <= '0;
                    end
                  end
                  default: begin
                  end
                endcase
              end
              CMD_TICK: begin
                if (play_state inside {ST_STOPPED, ST_PAUSED}) begin
                  seq <= S_EMIT;
                end else begin
                  seq <= S_MULS;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_MULS: begin
          seq <= S_MULV;
        end
        S_MULV: begin
          seq <= S_ADD;
        end
        S_ADD: begin
          seq <= S_WRAP;
        end
        S_WRAP: begin
          // Below zero always wraps up; at or past the end it wraps down
          // only when looping, otherwise the voice stops.
          if (np[NP_W-1]) begin
            seq <= S_WRAP;
          end else if (np >= len16 && loop_enable) begin
            seq <= S_WRAP;
          end else begin
            seq <= S_FINISH;
          end
        end
        S_FINISH: begin
          seq <= S_EMIT;
          if (stop_end) begin
            play_state  <= ST_STOPPED;
            position    <= '0;
            fade_volume <= '0;
          end else begin
            position    <= np[POS_W-1:0];
            fade_volume <= vol_clamped;
            if (play_state == ST_FADE_IN && vol_clamped >= 17'(VOL_ONE)) begin
              play_state <= ST_FULL;
            end else if (play_state == ST_FADE_PAUSE && vol_clamped == 17'd0) begin
              play_state <= ST_PAUSED;
            end else if (play_state == ST_FADE_STOP && vol_clamped == 17'd0) begin
              play_state  <= ST_STOPPED;
              position    <= '0;
              fade_volume <= '0;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            seq <= S_IDLE;
          end
        end
        default: begin
          seq <= S_IDLE;
        end
      endcase
    end
  end

  // Working registers of a tick; they carry no reset.
  always_ff @(posedge clk) begin
    case (seq)
      S_IDLE: begin
        speed_reg <= item.speed;
        stop_end  <= 1'b0;
        outv      <= '0;
      end
      S_MULV: begin
        // The product register holds speed times rate adjustment here.
        spd <= SPD_W'(prod >>> 14);
      end
      S_ADD: begin
        np <= alu_sum;
        if (play_state == ST_FULL) begin
          outv <= rd_data;
        end else begin
          outv <= prod_rnd[31:16];
        end
      end
      S_WRAP: begin
        if (np[NP_W-1]) begin
          np <= alu_sum;
        end else if (np >= len16) begin
          if (loop_enable) begin
            np <= alu_sum;
          end else begin
            stop_end <= 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule
